FILE: hdl/tfd_pkg.sv
// ----------------------------------------------------------------------------
// Telemetry frame deframer package
// Shared types, register indexes, reset values and the float decode function.
// ----------------------------------------------------------------------------
package tfd_pkg;

  // Frame length default
  localparam int unsigned FrameBytesDef = 16;

  // Configuration register indexes
  localparam logic [2:0] RegStartMarker  = 3'd0;
  localparam logic [2:0] RegSecondMarker = 3'd1;
  localparam logic [2:0] RegLatitudeId   = 3'd2;
  localparam logic [2:0] RegLongitudeId  = 3'd3;
  localparam logic [2:0] RegUnixTimeId   = 3'd4;

  // Configuration reset values
  localparam logic [7:0] StartMarkerRst  = 8'hFE;
  localparam logic [7:0] SecondMarkerRst = 8'h08;
  localparam logic [7:0] LatitudeIdRst   = 8'd20;
  localparam logic [7:0] LongitudeIdRst  = 8'd21;
  localparam logic [7:0] UnixTimeIdRst   = 8'd23;

  // Result kinds
  localparam logic [1:0] KindTimestamp = 2'd0;
  localparam logic [1:0] KindLatitude  = 2'd1;
  localparam logic [1:0] KindLongitude = 2'd2;
  localparam logic [1:0] KindUnixTime  = 2'd3;

  // Sync states
  localparam logic [1:0] SyncIdle  = 2'b00;
  localparam logic [1:0] SyncHalf  = 2'b01;
  localparam logic [1:0] SyncArmed = 2'b11;

  // Float exponent window
  localparam logic [7:0] ExpBias   = 8'd127;
  localparam logic [7:0] ExpMaxBia = 8'd135;

  // Packed output data width, padded to whole bytes
  localparam int unsigned OutDataW = 144;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [31:0]        stream_position;
    logic [7:0]         frame_id;
    logic [15:0]        seconds;
    logic [15:0]        microseconds;
    logic [31:0]        raw_word;
    logic signed [32:0] fixed_value;
    logic               range_error;
  } result_t;

  typedef struct packed {
    logic signed [32:0] fixed_value;
    logic               range_error;
  } decode_t;

  // Decode IEEE-754 single to signed Q9.23; out-of-window exponents flag an error
  function automatic decode_t decode_float(input logic [31:0] w);
    logic [7:0]  biased;
    logic [3:0]  sh;
    logic [32:0] mag;
    decode_t     r;
    biased = w[30:23];
    sh     = 4'(biased - ExpBias);
    mag    = {9'd0, 1'b1, w[22:0]} << sh;
    if (biased < ExpBias || biased > ExpMaxBia) begin
      r.fixed_value = '0;
      r.range_error = 1'b1;
    end else begin
      r.fixed_value = w[31] ? -$signed(mag) : $signed(mag);
      r.range_error = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: hdl/telemetry_frame_deframer.sv
// Results are registered: in the result register, or in the skid entry on a stall.
// Throughput: one byte per cycle; position nine of an armed frame, and position thirteen
// for a known id, yield a result, all other bytes only update the frame state.
// A two-entry output stage (result register plus skid entry) holds up to two results
// while the master side stalls; with both entries full, input stalls until one drains.
// rst_ni clears all control state and the registers to their documented reset values.
// ----------------------------------------------------------------------------
// Telemetry frame deframer
// Tracks frame position and sync, captures id and timestamp, decodes payload.
// ----------------------------------------------------------------------------
module telemetry_frame_deframer
  import tfd_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FrameBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_addr_i,
  input  logic [7:0]          cfg_data_i,
  // Input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [7:0] data_byte
  // Result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [31:0] stream_position, [39:32] frame_id, [55:40] seconds,
  // [71:56] microseconds, [103:72] raw_word, [136:104] fixed_value,
  // [137] range_error, [143:138] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic [1:0]          m_axis_tuser   // [1:0] result_kind
);

  localparam int unsigned PosW = $clog2(FRAME_BYTES);
  localparam logic [PosW-1:0] PosLast = PosW'(FRAME_BYTES - 1);

  // Configuration registers
  logic [7:0] start_marker_q, second_marker_q, latitude_id_q, longitude_id_q, unix_time_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q  <= StartMarkerRst;
      second_marker_q <= SecondMarkerRst;
      latitude_id_q   <= LatitudeIdRst;
      longitude_id_q  <= LongitudeIdRst;
      unix_time_id_q  <= UnixTimeIdRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegStartMarker:  start_marker_q  <= cfg_data_i;
        RegSecondMarker: second_marker_q <= cfg_data_i;
        RegLatitudeId:   latitude_id_q   <= cfg_data_i;
        RegLongitudeId:  longitude_id_q  <= cfg_data_i;
        RegUnixTimeId:   unix_time_id_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame state
  logic [PosW-1:0] pos_q, pos_d;
  logic [1:0]      sync_q, sync_d, sync_hold;
  logic [7:0]      id_q, id_d;
  logic [15:0]     usec_q, usec_d;
  logic [15:0]     sec_q, sec_d;
  logic [23:0]     low_q, low_d;
  logic [31:0]     count_q;

  logic       in_acc;
  logic [7:0] b;
  logic       armed;
  logic       res_valid;
  result_t    res;
  logic [31:0] word;
  decode_t    dec;

  assign in_acc = s_axis_tvalid & s_axis_tready;
  assign b      = s_axis_tdata;
  assign word   = {b, low_q};
  assign dec    = decode_float(word);

  // Update sync, capture fields and build the result for this byte
  always_comb begin
    sync_hold = sync_q;
    if (pos_q == '0 && b == start_marker_q) begin
      sync_hold = SyncHalf;
    end
    if (b == second_marker_q && sync_hold == SyncHalf) begin
      sync_hold = SyncArmed;
    end
    armed = (sync_hold == SyncArmed);

    id_d   = id_q;
    usec_d = usec_q;
    sec_d  = sec_q;
    low_d  = low_q;
    res_valid = 1'b0;
    res = '0;
    res.stream_position = count_q;
    res.frame_id        = id_q;
    res.microseconds    = usec_q;
    res.seconds         = sec_q;

    if (armed) begin
      case (pos_q)
        PosW'(5): id_d = b;
        PosW'(6): usec_d[7:0] = b;
        PosW'(7): usec_d[15:8] = b;
        PosW'(8): sec_d[7:0] = b;
        PosW'(9): begin
          sec_d[15:8]      = b;
          res.seconds      = {b, sec_q[7:0]};
          res.result_kind  = KindTimestamp;
          res_valid        = 1'b1;
        end
        PosW'(10): low_d[7:0]   = b;
        PosW'(11): low_d[15:8]  = b;
        PosW'(12): low_d[23:16] = b;
        PosW'(13): begin
          if (id_q == latitude_id_q || id_q == longitude_id_q) begin
            res.result_kind = (id_q == latitude_id_q) ? KindLatitude : KindLongitude;
            res.raw_word    = word;
            res.fixed_value = dec.fixed_value;
            res.range_error = dec.range_error;
            res_valid       = 1'b1;
          end else if (id_q == unix_time_id_q) begin
            res.result_kind = KindUnixTime;
            res.raw_word    = word;
            res_valid       = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // Advance the position; clear the frame at the wrap
    sync_d = sync_hold;
    if (pos_q == PosLast) begin
      pos_d  = '0;
      sync_d = SyncIdle;
      id_d   = '0;
      usec_d = '0;
      sec_d  = '0;
    end else begin
      pos_d = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      sync_q  <= SyncIdle;
      id_q    <= '0;
      usec_q  <= '0;
      sec_q   <= '0;
      low_q   <= '0;
      count_q <= '0;
    end else if (in_acc) begin
      pos_q   <= pos_d;
      sync_q  <= sync_d;
      id_q    <= id_d;
      usec_q  <= usec_d;
      sec_q   <= sec_d;
      low_q   <= low_d;
      count_q <= count_q + 32'd1;
    end
  end

  // Result register with a skid entry
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    new_valid;

  assign new_valid     = in_acc & res_valid;
  assign s_axis_tready = ~skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q  <= skid_valid_q | new_valid;
      skid_valid_q <= 1'b0;
    end else if (new_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (new_valid) begin
      skid_q <= res;
    end
  end

  // Drive the result stream
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.result_kind;
  assign m_axis_tdata  = {6'd0, out_q.range_error, out_q.fixed_value, out_q.raw_word,
                          out_q.microseconds, out_q.seconds, out_q.frame_id,
                          out_q.stream_position};

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// Telemetry frame deframer testbench
// Streams telemetry bytes into the deframer, in some phases under random idling on
// both sides, and checks every result, field by field, against an in-bench
// deframer model that follows the same frame, sync and float decode rules.
// ----------------------------------------------------------------------------
module tb;
  import tfd_pkg::*;

  localparam int          FrameLen      = FrameBytesDef;
  localparam int          DrainCycles   = 8;
  localparam int          HoldCycles    = 300;
  localparam int          WatchdogLimit = 4000;
  localparam logic [2:0]  RegUnused     = 3'd7;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [2:0]          cfg_addr_i    = '0;
  logic [7:0]          cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;

  telemetry_frame_deframer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Register copies shared by the frame builder and the deframer model
  logic [7:0] cfg_start  = StartMarkerRst;
  logic [7:0] cfg_second = SecondMarkerRst;
  logic [7:0] cfg_lat    = LatitudeIdRst;
  logic [7:0] cfg_lon    = LongitudeIdRst;
  logic [7:0] cfg_unix   = UnixTimeIdRst;

  // Deframer model state
  logic [3:0]  frm_pos   = '0;
  logic [1:0]  sync_st   = SyncIdle;
  logic [7:0]  cap_id    = '0;
  logic [15:0] usec_val  = '0;
  logic [15:0] sec_val   = '0;
  logic [23:0] pay_low   = '0;
  logic [31:0] bytes_seen = '0;

  logic [7:0] byte_q[$];
  result_t    pending_results[$];

  int  src_idle_pct = 0;
  int  rcv_idle_pct = 0;
  int  bytes_queued = 0;
  int  bytes_taken  = 0;
  int  frames_built = 0;
  int  errors       = 0;
  int  idle_cycles  = 0;
  int  hold_left    = 0;
  bit  hold_req     = 1'b0;
  bit  in_fired     = 1'b0;
  int  kind_cnt[4]  = '{0, 0, 0, 0};
  int  range_cnt    = 0;
  result_t want, got;

  // Clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Convert an IEEE-754 single to signed Q9.23, flag exponents outside 0..8
  function automatic void float_to_q923(input logic [31:0] w, output logic [32:0] q,
                                        output logic oor);
    int unsigned e;
    logic [32:0] mag;
    e = 32'(w[30:23]);
    if (e < ExpBias || e > ExpMaxBia) begin
      q   = '0;
      oor = 1'b1;
    end else begin
      mag = {9'd0, 1'b1, w[22:0]};
      mag = mag << (e - ExpBias);
      q   = w[31] ? (~mag + 33'd1) : mag;
      oor = 1'b0;
    end
  endfunction

  // Advance the deframer model by one byte, queue the result it yields
  function automatic void deframe_byte(input logic [7:0] b);
    result_t     r;
    logic        hit;
    logic [31:0] w;
    logic [32:0] q;
    logic        oor;
    r   = '0;
    hit = 1'b0;
    if (frm_pos == 0 && b == cfg_start) sync_st = SyncHalf;
    if (b == cfg_second && sync_st == SyncHalf) sync_st = SyncArmed;
    if (sync_st == SyncArmed) begin
      case (frm_pos)
        4'd5:  cap_id = b;
        4'd6:  usec_val[7:0] = b;
        4'd7:  usec_val[15:8] = b;
        4'd8:  sec_val[7:0] = b;
        4'd9: begin
          sec_val[15:8] = b;
          r.result_kind = KindTimestamp;
          hit = 1'b1;
        end
        4'd10: pay_low[7:0] = b;
        4'd11: pay_low[15:8] = b;
        4'd12: pay_low[23:16] = b;
        4'd13: begin
          w = {b, pay_low};
          if (cap_id == cfg_lat || cap_id == cfg_lon) begin
            r.result_kind = (cap_id == cfg_lat) ? KindLatitude : KindLongitude;
            r.raw_word    = w;
            float_to_q923(w, q, oor);
            r.fixed_value = q;
            r.range_error = oor;
            hit = 1'b1;
          end else if (cap_id == cfg_unix) begin
            r.result_kind = KindUnixTime;
            r.raw_word    = w;
            hit = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (hit) begin
      r.stream_position = bytes_seen;
      r.frame_id        = cap_id;
      r.seconds         = sec_val;
      r.microseconds    = usec_val;
      pending_results.push_back(r);
    end
    bytes_seen = bytes_seen + 1;
    if (frm_pos == FrameLen - 1) begin
      frm_pos  = '0;
      sync_st  = SyncIdle;
      cap_id   = '0;
      usec_val = '0;
      sec_val  = '0;
    end else begin
      frm_pos = frm_pos + 1'b1;
    end
  endfunction

  // Report a field that differs from its expected value
  function automatic void cmp_field(input string fname, input logic [32:0] exp_v,
                                    input logic [32:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v, act_v);
      errors++;
    end
  endfunction

  // Sender: offer the next queued byte, hold it until it is taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_fired) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_axis_tdata  <= byte_q.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      in_fired = 1'b0;
    end
  end

  // Input side: feed every accepted byte to the model
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      deframe_byte(s_axis_tdata);
      bytes_taken++;
      in_fired = 1'b1;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Output side: compare each accepted item with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d position %0h",
                 $time, m_axis_tuser, m_axis_tdata[31:0]);
        errors++;
      end else begin
        want = pending_results.pop_front();
        got.result_kind     = m_axis_tuser;
        got.stream_position = m_axis_tdata[31:0];
        got.frame_id        = m_axis_tdata[39:32];
        got.seconds         = m_axis_tdata[55:40];
        got.microseconds    = m_axis_tdata[71:56];
        got.raw_word        = m_axis_tdata[103:72];
        got.fixed_value     = m_axis_tdata[136:104];
        got.range_error     = m_axis_tdata[137];
        cmp_field("result_kind", want.result_kind, got.result_kind);
        cmp_field("stream_position", want.stream_position, got.stream_position);
        cmp_field("frame_id", want.frame_id, got.frame_id);
        cmp_field("seconds", want.seconds, got.seconds);
        cmp_field("microseconds", want.microseconds, got.microseconds);
        cmp_field("raw_word", want.raw_word, got.raw_word);
        cmp_field("fixed_value", want.fixed_value, got.fixed_value);
        cmp_field("range_error", want.range_error, got.range_error);
        kind_cnt[want.result_kind]++;
        if (want.range_error) range_cnt++;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no progress for %0d cycles", $time, WatchdogLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Write one register at the next rising edge and track it
  task automatic set_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    case (idx)
      RegStartMarker:  cfg_start  = val;
      RegSecondMarker: cfg_second = val;
      RegLatitudeId:   cfg_lat    = val;
      RegLongitudeId:  cfg_lon    = val;
      RegUnixTimeId:   cfg_unix   = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Pick a payload word: mostly in-window exponents, some zero, denormal,
  // infinity, NaN and arbitrary exponents
  function automatic logic [31:0] pick_word();
    logic [7:0]  e;
    logic [22:0] m;
    int          r;
    r = $urandom_range(99);
    if (r < 70)      e = ExpBias + 8'($urandom_range(8));
    else if (r < 80) e = 8'h00;
    else if (r < 90) e = 8'hFF;
    else             e = 8'($urandom_range(255));
    r = $urandom_range(9);
    if (r == 0)      m = '0;
    else if (r == 1) m = '1;
    else             m = 23'($urandom);
    return {1'($urandom_range(1)), e, m};
  endfunction

  // Queue one frame: well-formed, late arming, half-armed only, or noise
  task automatic build_frame();
    logic [7:0]  fr[FrameLen];
    logic [31:0] w;
    int          kind;
    int          arm_at;
    int          r;
    kind = $urandom_range(99);
    foreach (fr[i]) fr[i] = 8'($urandom_range(255));
    if (kind < 90) begin
      r = $urandom_range(9);
      if (r < 3)      fr[5] = cfg_lat;
      else if (r < 6) fr[5] = cfg_lon;
      else if (r < 8) fr[5] = cfg_unix;
      w = pick_word();
      fr[10] = w[7:0];
      fr[11] = w[15:8];
      fr[12] = w[23:16];
      fr[13] = w[31:24];
      fr[0]  = cfg_start;
      if (kind < 65) arm_at = $urandom_range(4, 1);
      else if (kind < 80) arm_at = $urandom_range(13, 5);
      else arm_at = FrameLen;
      // keep the second marker away until the chosen arming point
      for (int i = 1; i < FrameLen; i++) begin
        if (i < arm_at && fr[i] == cfg_second) fr[i] = ~cfg_second;
      end
      if (arm_at < FrameLen) fr[arm_at] = cfg_second;
    end
    foreach (fr[i]) byte_q.push_back(fr[i]);
    bytes_queued += FrameLen;
    frames_built++;
  endtask

  // Align to a frame boundary, queue frames, wait until all results are in
  task automatic run_frames(input int n_frames, input bit with_hold);
    int pad;
    @(posedge clk_i);
    pad = (FrameLen - (bytes_queued % FrameLen)) % FrameLen;
    repeat (pad) byte_q.push_back(8'($urandom_range(255)));
    bytes_queued += pad;
    repeat (n_frames) build_frame();
    if (with_hold) begin
      repeat (20) @(posedge clk_i);
      hold_req = 1'b1;
    end
    @(negedge clk_i);
    while (bytes_taken != bytes_queued || pending_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Directed frames for the reset register values
  logic [7:0] frame_full[FrameLen] = '{
    8'hFE, 8'h08, 8'h00, 8'hFF, 8'h5A, 8'h14, 8'hFF, 8'hFF,
    8'h00, 8'h00, 8'hFF, 8'hFF, 8'h7F, 8'hC3, 8'h00, 8'hFF};
  // late arming at position seven, marker lands in microseconds, unknown id
  logic [7:0] frame_late[FrameLen] = '{
    8'hFE, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h08,
    8'h34, 8'h12, 8'h00, 8'h00, 8'h80, 8'h3F, 8'hA5, 8'h5A};

  // Stimulus
  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Phase 1: reset registers, sender idles lightly, receiver heavily
    src_idle_pct = 32;
    rcv_idle_pct = 79;
    foreach (frame_full[i]) byte_q.push_back(frame_full[i]);
    foreach (frame_late[i]) byte_q.push_back(frame_late[i]);
    bytes_queued += 2 * FrameLen;
    frames_built += 2;
    run_frames(16, 1'b1);

    // Phase 2: extreme register values, idling swapped
    set_reg(RegStartMarker, 8'h00);
    set_reg(RegSecondMarker, 8'hFF);
    set_reg(RegLatitudeId, 8'hFF);
    set_reg(RegLongitudeId, 8'h00);
    set_reg(RegUnixTimeId, 8'h80);
    cfg_we_i <= 1'b0;
    src_idle_pct = 79;
    rcv_idle_pct = 32;
    run_frames(16, 1'b0);

    // Phase 3: equal markers, latitude and longitude share an id, no idling
    set_reg(RegStartMarker, 8'hFF);
    set_reg(RegSecondMarker, 8'hFF);
    set_reg(RegLatitudeId, 8'h10);
    set_reg(RegLongitudeId, 8'h10);
    set_reg(RegUnixTimeId, 8'h7F);
    set_reg(RegUnused, 8'hA5);
    cfg_we_i <= 1'b0;
    src_idle_pct = 0;
    rcv_idle_pct = 0;
    run_frames(16, 1'b1);

    // Phase 4: zero markers, longitude and unix time share an id
    set_reg(RegStartMarker, 8'h00);
    set_reg(RegSecondMarker, 8'h00);
    set_reg(RegLatitudeId, 8'h01);
    set_reg(RegLongitudeId, 8'h02);
    set_reg(RegUnixTimeId, 8'h02);
    cfg_we_i <= 1'b0;
    run_frames(16, 1'b0);

    $display("Sent %0d bytes in %0d frames over four register settings.",
             bytes_taken, frames_built);
    $display("Checked results: %0d timestamp, %0d latitude, %0d longitude,",
             kind_cnt[KindTimestamp], kind_cnt[KindLatitude], kind_cnt[KindLongitude]);
    $display("  %0d unix time, %0d out of range.", kind_cnt[KindUnixTime], range_cnt);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: telemetry_frame_deframer.f
hdl/tfd_pkg.sv
hdl/telemetry_frame_deframer.sv
sim/tb.sv
